// ----- hw/rtl/i2cbs_pkg.sv -----
package i2cbs_pkg;

  // bus commands carried on the input tuser
  localparam logic [2:0] REQ_INIT  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_SEND  = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // phase hold times in 100 ns units
  localparam logic [3:0] HOLD_ZERO = 4'd0;
  localparam logic [3:0] HOLD_0U4  = 4'd4;
  localparam logic [3:0] HOLD_0U6  = 4'd6;
  localparam logic [3:0] HOLD_0U8  = 4'd8;
  localparam logic [3:0] HOLD_0U9  = 4'd9;
  localparam logic [3:0] HOLD_1U0  = 4'd10;
  localparam logic [3:0] HOLD_1U1  = 4'd11;
  localparam logic [3:0] HOLD_1U3  = 4'd13;

  localparam int unsigned ByteBits = 8;

  // one pin phase: which line state changes, its hold, and status marks
  typedef struct packed {
    logic       set_scl;
    logic       scl;
    logic       set_sda;
    logic       sda;
    logic       set_drv;
    logic       drv;
    logic [3:0] hold;
    logic       last;
    logic       ack;
    logic       rx;
  } phase_t;

  // control of the data and sample shift registers
  typedef struct packed {
    logic load;
    logic shift_tx;
    logic shift_rx;
  } shift_ctl_t;

endpackage

// ----- hw/rtl/i2cbs_shift.sv -----
module i2cbs_shift (
  input  logic                     clk_i,
  input  i2cbs_pkg::shift_ctl_t    ctl_i,
  input  logic [7:0]               tx_byte_i,
  input  logic [7:0]               sda_samples_i,
  output logic                     tx_bit_o,
  output logic                     smp_bit_o,
  output logic [7:0]               rx_byte_o
);
  import i2cbs_pkg::*;

  logic [ByteBits-1:0] tx_sh_q;
  logic [ByteBits-1:0] smp_sh_q;
  logic [ByteBits-1:0] rx_sh_q;

  // one bit per bus clock: data out msb first, samples in msb first
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      tx_sh_q  <= tx_byte_i;
      smp_sh_q <= sda_samples_i;
      rx_sh_q  <= '0;
    end else begin
      if (ctl_i.shift_tx) begin
        tx_sh_q <= {tx_sh_q[ByteBits-2:0], 1'b0};
      end
      if (ctl_i.shift_rx) begin
        smp_sh_q <= {smp_sh_q[ByteBits-2:0], 1'b0};
        rx_sh_q  <= {rx_sh_q[ByteBits-2:0], smp_sh_q[ByteBits-1]};
      end
    end
  end

  assign tx_bit_o  = tx_sh_q[ByteBits-1];
  assign smp_bit_o = smp_sh_q[ByteBits-1];
  assign rx_byte_o = rx_sh_q;

endmodule

// ----- hw/rtl/i2cbs_seq.sv -----
module i2cbs_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2:0]            req_i,
  input  logic                  emit_i,
  input  logic                  tx_bit_i,
  output logic                  busy_o,
  output i2cbs_pkg::phase_t     phase_o,
  output i2cbs_pkg::shift_ctl_t shift_o
);
  import i2cbs_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_INIT     = 4'd1;
  localparam logic [3:0] ST_START    = 4'd2;
  localparam logic [3:0] ST_STOP     = 4'd3;
  localparam logic [3:0] ST_SEND_BIT = 4'd4;
  localparam logic [3:0] ST_SEND_ACK = 4'd5;
  localparam logic [3:0] ST_READ_REL = 4'd6;
  localparam logic [3:0] ST_READ_BIT = 4'd7;
  localparam logic [3:0] ST_READ_ACK = 4'd8;

  localparam logic [2:0] LAST_BIT = 3'(ByteBits - 1);

  logic [3:0] st_q, st_d, nxt_st;
  logic [2:0] sub_q, sub_d;
  logic [2:0] bit_q, bit_d, nxt_bit;
  logic       grp_end;
  phase_t     ph;

  always_comb begin
    ph      = '0;
    grp_end = 1'b0;
    nxt_st  = ST_IDLE;
    nxt_bit = 3'd0;
    case (st_q)
      ST_INIT: begin
        ph.set_scl = 1'b1; ph.scl = 1'b1;
        ph.set_sda = 1'b1; ph.sda = 1'b1;
        ph.set_drv = 1'b1; ph.drv = 1'b1;
        ph.hold    = HOLD_ZERO;
        ph.last    = 1'b1;
        grp_end    = 1'b1;
      end
      ST_START: begin
        if (sub_q == 3'd0) begin
          ph.set_sda = 1'b1; ph.sda = 1'b0; ph.hold = HOLD_1U3;
        end else begin
          ph.set_scl = 1'b1; ph.scl = 1'b0; ph.hold = HOLD_0U6;
          ph.last    = 1'b1;
          grp_end    = 1'b1;
        end
      end
      ST_STOP: begin
        if (sub_q == 3'd0) begin
          ph.set_scl = 1'b1; ph.scl = 1'b1; ph.hold = HOLD_1U3;
        end else begin
          ph.set_sda = 1'b1; ph.sda = 1'b1; ph.hold = HOLD_1U3;
          ph.last    = 1'b1;
          grp_end    = 1'b1;
        end
      end
      ST_SEND_BIT: begin
        case (sub_q)
          3'd0: begin
            ph.set_sda = 1'b1; ph.sda = tx_bit_i; ph.hold = HOLD_0U4;
          end
          3'd1: begin
            ph.set_scl = 1'b1; ph.scl = 1'b1; ph.hold = HOLD_1U1;
          end
          default: begin
            ph.set_scl = 1'b1; ph.scl = 1'b0;
            ph.hold    = (bit_q == LAST_BIT) ? HOLD_1U0 : HOLD_ZERO;
            grp_end    = 1'b1;
            nxt_st     = (bit_q == LAST_BIT) ? ST_SEND_ACK : ST_SEND_BIT;
            nxt_bit    = (bit_q == LAST_BIT) ? 3'd0 : bit_q + 3'd1;
          end
        endcase
      end
      ST_SEND_ACK: begin
        case (sub_q)
          3'd0: begin
            ph.set_sda = 1'b1; ph.sda = 1'b1;
            ph.set_drv = 1'b1; ph.drv = 1'b0;
            ph.hold    = HOLD_ZERO;
          end
          3'd1: begin
            ph.set_scl = 1'b1; ph.scl = 1'b1; ph.hold = HOLD_1U3;
          end
          3'd2: begin
            ph.set_scl = 1'b1; ph.scl = 1'b0; ph.hold = HOLD_ZERO;
          end
          3'd3: begin
            ph.set_drv = 1'b1; ph.drv = 1'b1; ph.hold = HOLD_1U3;
          end
          default: begin
            ph.set_sda = 1'b1; ph.sda = 1'b0; ph.hold = HOLD_ZERO;
            ph.last    = 1'b1;
            ph.ack     = 1'b1;
            grp_end    = 1'b1;
          end
        endcase
      end
      ST_READ_REL: begin
        ph.set_sda = 1'b1; ph.sda = 1'b1;
        ph.set_drv = 1'b1; ph.drv = 1'b0;
        ph.hold    = HOLD_0U9;
        grp_end    = 1'b1;
        nxt_st     = ST_READ_BIT;
      end
      ST_READ_BIT: begin
        if (sub_q == 3'd0) begin
          ph.set_scl = 1'b1; ph.scl = 1'b1; ph.hold = HOLD_0U9;
        end else begin
          ph.set_scl = 1'b1; ph.scl = 1'b0;
          ph.hold    = (bit_q == LAST_BIT) ? HOLD_ZERO : HOLD_0U9;
          grp_end    = 1'b1;
          nxt_st     = (bit_q == LAST_BIT) ? ST_READ_ACK : ST_READ_BIT;
          nxt_bit    = (bit_q == LAST_BIT) ? 3'd0 : bit_q + 3'd1;
        end
      end
      ST_READ_ACK: begin
        case (sub_q)
          3'd0: begin
            ph.set_drv = 1'b1; ph.drv = 1'b1; ph.hold = HOLD_ZERO;
          end
          3'd1: begin
            ph.set_sda = 1'b1; ph.sda = 1'b0; ph.hold = HOLD_0U8;
          end
          3'd2: begin
            ph.set_scl = 1'b1; ph.scl = 1'b1; ph.hold = HOLD_1U3;
          end
          default: begin
            ph.set_scl = 1'b1; ph.scl = 1'b0; ph.hold = HOLD_1U3;
            ph.last    = 1'b1;
            ph.rx      = 1'b1;
            grp_end    = 1'b1;
          end
        endcase
      end
      default: begin
        ph = '0;
      end
    endcase
  end

  always_comb begin
    st_d  = st_q;
    sub_d = sub_q;
    bit_d = bit_q;
    if (start_i) begin
      sub_d = 3'd0;
      bit_d = 3'd0;
      case (req_i)
        REQ_INIT:  st_d = ST_INIT;
        REQ_START: st_d = ST_START;
        REQ_STOP:  st_d = ST_STOP;
        REQ_SEND:  st_d = ST_SEND_BIT;
        REQ_READ:  st_d = ST_READ_REL;
        default:   st_d = ST_IDLE;
      endcase
    end else if (emit_i) begin
      if (grp_end) begin
        st_d  = nxt_st;
        sub_d = 3'd0;
        bit_d = nxt_bit;
      end else begin
        sub_d = sub_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      sub_q <= 3'd0;
      bit_q <= 3'd0;
    end else begin
      st_q  <= st_d;
      sub_q <= sub_d;
      bit_q <= bit_d;
    end
  end

  assign busy_o          = (st_q != ST_IDLE);
  assign phase_o         = ph;
  assign shift_o.load    = start_i;
  assign shift_o.shift_tx = emit_i && (st_q == ST_SEND_BIT) && (sub_q == 3'd2);
  assign shift_o.shift_rx = emit_i && (st_q == ST_READ_BIT) && (sub_q == 3'd0);

  // a finished command leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_i && ph.last |=> st_q == ST_IDLE)
    else $error("sequencer still busy after last phase");

  // no new command lands on a running one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> st_q == ST_IDLE)
    else $error("command taken while sequencer busy");

endmodule

// ----- hw/rtl/i2c_master_bit_sequencer_core.sv -----
// channel  | dir | handshake               | payload
// ---------+-----+-------------------------+------------------------------------------
// command  | in  | s_axis_tvalid/tready    | tuser req_type, tdata tx_byte, sda_samples
// phase    | out | m_axis_tvalid/tready    | tdata pin phase, tlast last_phase
//
// one command transfer is taken when the sequencer is idle; its phases then leave
// one per cycle while the sink is ready, n phases per command with n =
// 1 (init), 2 (start, stop), 29 (send), 21 (read), set by the phase sequencer
// stepping through bit slots and the byte-wide shift registers behind it
// hold times are emitted as numbers, they are not counted out here
// reset puts scl, sda high and sda driven, and empties the output register
// a stalled sink freezes the sequencer; unknown commands are taken and dropped
module i2c_master_bit_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
  input  logic [15:0] s_axis_tdata,   // [7:0] tx_byte, [15:8] sda_samples
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] scl_level, [1] sda_level, [2] sda_drive,
                                      // [6:3] hold_units, [7] ack_seen, [15:8] rx_byte
  output logic        m_axis_tlast    // last_phase
);
  import i2cbs_pkg::*;

  i2cbs_pkg::phase_t     phase;
  i2cbs_pkg::shift_ctl_t shift_ctl;

  logic       busy;
  logic       start;
  logic       emit;
  logic       tx_bit;
  logic       smp_bit;
  logic [7:0] rx_byte;

  // current line state
  logic scl_q, scl_d;
  logic sda_q, sda_d;
  logic drv_q, drv_d;

  // output register
  logic        out_valid_q;
  logic [15:0] out_data_q, out_data_d;
  logic        out_last_q;

  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && s_axis_tready;
  // a phase leaves when the output register is free or being drained
  assign emit          = busy && (!out_valid_q || m_axis_tready);

  i2cbs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .req_i    (s_axis_tuser),
    .emit_i   (emit),
    .tx_bit_i (tx_bit),
    .busy_o   (busy),
    .phase_o  (phase),
    .shift_o  (shift_ctl)
  );

  i2cbs_shift u_shift (
    .clk_i         (clk_i),
    .ctl_i         (shift_ctl),
    .tx_byte_i     (s_axis_tdata[7:0]),
    .sda_samples_i (s_axis_tdata[15:8]),
    .tx_bit_o      (tx_bit),
    .smp_bit_o     (smp_bit),
    .rx_byte_o     (rx_byte)
  );

  // apply the phase change to the line state
  always_comb begin
    scl_d = phase.set_scl ? phase.scl : scl_q;
    sda_d = phase.set_sda ? phase.sda : sda_q;
    drv_d = phase.set_drv ? phase.drv : drv_q;
    out_data_d        = '0;
    out_data_d[0]     = scl_d;
    out_data_d[1]     = drv_d ? sda_d : 1'b1;   // released line reads pulled up
    out_data_d[2]     = drv_d;
    out_data_d[6:3]   = phase.hold;
    out_data_d[7]     = phase.ack && !smp_bit;  // ack is a low sample
    out_data_d[15:8]  = phase.rx ? rx_byte : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        drv_q       <= drv_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= out_data_d;
      out_last_q <= phase.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // ack and received byte only ride on the closing phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7] || m_axis_tdata[15:8] != 8'd0) |-> m_axis_tlast)
    else $error("status field outside last phase");

  // a released sda always shows the pull-up level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[1])
    else $error("released sda not reading high");

  // line state only moves when a phase is emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(emit) |-> $stable(scl_q) && $stable(sda_q) && $stable(drv_q))
    else $error("line state changed without a phase");

endmodule

// ----- tb/i2c_master_bit_sequencer_core_test.sv -----
module i2c_master_bit_sequencer_core_test;
  import i2cbs_pkg::*;

  // command codes the sequencer does not know; taken and dropped
  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  localparam int unsigned NumCmds     = 430;
  localparam int unsigned QuietLimit  = 20000;
  localparam int unsigned HoldoffLen  = 4000;
  localparam int unsigned HoldoffAt   = 300;
  localparam int unsigned DrainCycles = 60;

  // one bus command as offered on the input channel
  typedef struct packed {
    logic [2:0] req;
    logic [7:0] tx;
    logic [7:0] smp;
  } bus_cmd_t;

  // one pin phase as it leaves on the output channel
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic [3:0] hold;
    logic       last;
    logic       ack;
    logic [7:0] rx;
  } pin_phase_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser  = '0;   // [2:0] req_type
  logic [15:0] s_axis_tdata  = '0;   // [7:0] tx_byte, [15:8] sda_samples
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] scl, [1] sda, [2] drive, [6:3] hold,
                                     // [7] ack_seen, [15:8] rx_byte
  logic        m_axis_tlast;         // last_phase

  i2c_master_bit_sequencer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  bus_cmd_t   cmd_q[$];      // commands not yet offered
  bus_cmd_t   cmd_now;       // command on the input channel
  pin_phase_t phase_q[$];    // phases the bus should show, oldest first
  int         real_cmds = 0;
  int         mismatches = 0;
  int         phases_seen = 0;
  int         holdoff_left = 0;
  logic       holdoff_done = 1'b0;

  // line state of the bus as the sequencer sees it
  logic bus_scl = 1'b1;
  logic bus_sda = 1'b1;
  logic bus_drv = 1'b1;

  task automatic add_cmd(input logic [2:0] req, input logic [7:0] tx, input logic [7:0] smp);
    bus_cmd_t c;
    c.req = req;
    c.tx  = tx;
    c.smp = smp;
    cmd_q.push_back(c);
    if (req <= REQ_READ) real_cmds++;
  endtask

  // current line state with a given hold; a released sda reads as pull-up
  function automatic pin_phase_t snap(input logic [3:0] hold);
    pin_phase_t p;
    p.scl  = bus_scl;
    p.sda  = bus_drv ? bus_sda : 1'b1;
    p.drv  = bus_drv;
    p.hold = hold;
    p.last = 1'b0;
    p.ack  = 1'b0;
    p.rx   = '0;
    return p;
  endfunction

  // expand one accepted command into its pin phases and advance the line state
  task automatic expand_command(input bus_cmd_t c);
    pin_phase_t seq[$];
    pin_phase_t tail;
    case (c.req)
      REQ_INIT: begin
        bus_drv = 1'b1;
        bus_scl = 1'b1;
        bus_sda = 1'b1;
        seq.push_back(snap(HOLD_ZERO));
      end
      REQ_START: begin
        bus_sda = 1'b0;
        seq.push_back(snap(HOLD_1U3));
        bus_scl = 1'b0;
        seq.push_back(snap(HOLD_0U6));
      end
      REQ_STOP: begin
        bus_scl = 1'b1;
        seq.push_back(snap(HOLD_1U3));
        bus_sda = 1'b1;
        seq.push_back(snap(HOLD_1U3));
      end
      REQ_SEND: begin
        for (int b = 7; b >= 0; b--) begin
          bus_sda = c.tx[b];
          seq.push_back(snap(HOLD_0U4));
          bus_scl = 1'b1;
          seq.push_back(snap(HOLD_1U1));
          bus_scl = 1'b0;
          seq.push_back(snap(b == 0 ? HOLD_1U0 : HOLD_ZERO));
        end
        // release sda for the acknowledge clock
        bus_sda = 1'b1;
        bus_drv = 1'b0;
        seq.push_back(snap(HOLD_ZERO));
        bus_scl = 1'b1;
        seq.push_back(snap(HOLD_1U3));
        bus_scl = 1'b0;
        seq.push_back(snap(HOLD_ZERO));
        bus_drv = 1'b1;
        seq.push_back(snap(HOLD_1U3));
        bus_sda = 1'b0;
        seq.push_back(snap(HOLD_ZERO));
      end
      REQ_READ: begin
        bus_sda = 1'b1;
        bus_drv = 1'b0;
        seq.push_back(snap(HOLD_0U9));
        for (int b = 0; b < ByteBits; b++) begin
          bus_scl = 1'b1;
          seq.push_back(snap(HOLD_0U9));
          bus_scl = 1'b0;
          seq.push_back(snap(b == ByteBits - 1 ? HOLD_ZERO : HOLD_0U9));
        end
        // master acknowledges every byte
        bus_drv = 1'b1;
        seq.push_back(snap(HOLD_ZERO));
        bus_sda = 1'b0;
        seq.push_back(snap(HOLD_0U8));
        bus_scl = 1'b1;
        seq.push_back(snap(HOLD_1U3));
        bus_scl = 1'b0;
        seq.push_back(snap(HOLD_1U3));
      end
      default: ;  // unknown command leaves no trace
    endcase
    if (seq.size() != 0) begin
      tail = seq.pop_back();
      tail.last = 1'b1;
      if (c.req == REQ_SEND) tail.ack = ~c.smp[7];
      if (c.req == REQ_READ) tail.rx = c.smp;
      seq.push_back(tail);
    end
    foreach (seq[i]) phase_q.push_back(seq[i]);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // command driver: one gap drawn per command, with runs of back-to-back transfers
  int src_wait = 0;
  int src_run  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tuser  <= '0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expand_command(cmd_now);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_wait > 0) begin
          src_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cmd_now = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cmd_now.req;
          s_axis_tdata  <= {cmd_now.smp, cmd_now.tx};
          if (src_run > 0) begin
            src_run--;
            src_wait = 0;
          end else begin
            src_wait = $urandom_range(0, 19);
            if ($urandom_range(0, 15) == 0) src_run = $urandom_range(10, 40);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // phase monitor and sink pacing
  int snk_wait = 0;
  int snk_run  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    pin_phase_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        phases_seen <= phases_seen + 1;
        if (phase_q.size() == 0) begin
          $error("phase transfer with nothing expected: tdata %h tlast %b",
                 m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = phase_q.pop_front();
          check_field("scl_level",  want.scl,  m_axis_tdata[0]);
          check_field("sda_level",  want.sda,  m_axis_tdata[1]);
          check_field("sda_drive",  want.drv,  m_axis_tdata[2]);
          check_field("hold_units", want.hold, m_axis_tdata[6:3]);
          check_field("ack_seen",   want.ack,  m_axis_tdata[7]);
          check_field("rx_byte",    want.rx,   m_axis_tdata[15:8]);
          check_field("last_phase", want.last, m_axis_tlast);
        end
        if (snk_run > 0) begin
          snk_run--;
          snk_wait = 0;
        end else begin
          snk_wait = $urandom_range(0, 19);
          if ($urandom_range(0, 15) == 0) snk_run = $urandom_range(10, 40);
        end
      end
      if (holdoff_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one long sink hold-off so the sequencer freezes and backs up the command side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!holdoff_done && phases_seen >= HoldoffAt) begin
        holdoff_left <= HoldoffLen;
        holdoff_done <= 1'b1;
      end else if (holdoff_left != 0) begin
        holdoff_left <= holdoff_left - 1;
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int  nbytes;
    logic repeat_start;

    // directed: every command, byte extremes, ack and nack, unknown codes
    add_cmd(REQ_INIT,  8'h00, 8'h00);
    add_cmd(REQ_START, 8'h00, 8'h00);
    add_cmd(REQ_SEND,  8'h00, 8'h00);
    add_cmd(REQ_SEND,  8'hff, 8'h80);
    add_cmd(REQ_SEND,  8'ha5, 8'h7f);
    add_cmd(REQ_READ,  8'h00, 8'h00);
    add_cmd(REQ_READ,  8'hff, 8'hff);
    add_cmd(REQ_READ,  8'h5a, 8'h5a);
    add_cmd(REQ_STOP,  8'hff, 8'hff);
    add_cmd(REQ_RSVD5, 8'hff, 8'hff);
    add_cmd(REQ_RSVD6, 8'h00, 8'h00);
    add_cmd(REQ_RSVD7, 8'h3c, 8'hc3);
    add_cmd(REQ_START, 8'hff, 8'hff);
    add_cmd(REQ_SEND,  8'h3c, 8'hff);
    add_cmd(REQ_START, 8'h00, 8'h00);   // repeated start
    add_cmd(REQ_READ,  8'h00, 8'hc3);
    add_cmd(REQ_STOP,  8'h00, 8'h00);
    add_cmd(REQ_STOP,  8'h00, 8'h00);   // stop with no open transaction
    add_cmd(REQ_READ,  8'h00, 8'h81);   // read outside a transaction
    add_cmd(REQ_INIT,  8'hff, 8'hff);
    add_cmd(REQ_INIT,  8'h00, 8'h00);

    // random: mostly well-formed transactions, some loose commands and noise
    repeat_start = 1'b0;
    while (real_cmds < NumCmds) begin
      if ($urandom_range(0, 9) < 8) begin
        if (!repeat_start && $urandom_range(0, 7) == 0) begin
          add_cmd(REQ_INIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        add_cmd(REQ_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        // address byte, mostly acknowledged
        add_cmd(REQ_SEND, 8'($urandom_range(0, 255)),
                {($urandom_range(0, 3) == 0), 7'($urandom_range(0, 127))});
        nbytes = $urandom_range(0, 4);
        for (int k = 0; k < nbytes; k++) begin
          add_cmd($urandom_range(0, 1) ? REQ_SEND : REQ_READ,
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        repeat_start = ($urandom_range(0, 4) == 0);
        if (!repeat_start) add_cmd(REQ_STOP, 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)));
      end else begin
        add_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every command to go in and every phase to come out; checked
    // mid-cycle so the driver and monitor updates of the edge have settled
    while (cmd_q.size() != 0 || s_axis_tvalid || phase_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && phase_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
